@@ rtl/dmgt_pkg.sv @@
// ----------------------------------------------------------------------------
// dmgt_pkg
// Shared types, register addresses and constants for the divider / timer.
// ----------------------------------------------------------------------------
package dmgt_pkg;

  localparam int unsigned ElapsedBitsDefault = 8;

  localparam int unsigned DivBits   = 16;
  localparam int unsigned ByteBits  = 8;
  localparam int unsigned AddrBits  = 16;
  localparam int unsigned CtrlBits  = 3;
  localparam int unsigned PeriodBits = 11;

  // Opcodes
  localparam logic [1:0] OpAdvance = 2'd0;
  localparam logic [1:0] OpRead    = 2'd1;
  localparam logic [1:0] OpWrite   = 2'd2;

  // Register addresses
  localparam logic [AddrBits-1:0] AddrDiv  = 16'hFF04;
  localparam logic [AddrBits-1:0] AddrTima = 16'hFF05;
  localparam logic [AddrBits-1:0] AddrTma  = 16'hFF06;
  localparam logic [AddrBits-1:0] AddrTac  = 16'hFF07;

  localparam int unsigned  TacEnableBit = 2;
  localparam logic [7:0]   TacReadOnes  = 8'hF8;
  localparam logic [7:0]   OpenBus      = 8'hFF;
  localparam logic [7:0]   CounterMax   = 8'hFF;

  // Controller to datapath
  typedef struct packed {
    logic load;    // take the accepted transaction, advance divider and, if enabled, accumulator
    logic step;    // one prescale step: accumulator minus period, counter plus one or reload on overflow
    logic finish;  // register access and result capture
  } dmgt_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic step_due;  // timer enabled and accumulator at or above the period
    logic out_free;  // result register can take a new result this cycle
  } dmgt_status_t;

  function automatic logic [PeriodBits-1:0] step_period(input logic [1:0] sel);
    logic [PeriodBits-1:0] p;
    unique case (sel)
      2'd0:    p = 11'd1024;
      2'd1:    p = 11'd16;
      2'd2:    p = 11'd64;
      default: p = 11'd256;
    endcase
    return p;
  endfunction

endpackage

@@ rtl/dmgt_ctrl.sv @@
// ----------------------------------------------------------------------------
// dmgt_ctrl
// Sequencer: accepts a transaction, runs prescale steps, then finishes.
// ----------------------------------------------------------------------------
module dmgt_ctrl import dmgt_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_stall_o,
  input  dmgt_status_t status_i,
  output dmgt_cmd_t    cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE  = 2'b01,
    S_DRAIN = 2'b10
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_stall_o  = 1'b1;
    unique case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (status_i.step_due) begin
          cmd_o.step = 1'b1;
        end else if (status_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ rtl/dmgt_datapath.sv @@
// ----------------------------------------------------------------------------
// dmgt_datapath
// Divider, prescale accumulator, counter, registers and the result register.
// ----------------------------------------------------------------------------
module dmgt_datapath import dmgt_pkg::*; #(
  parameter int unsigned ElapsedBits = ElapsedBitsDefault
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  dmgt_cmd_t              cmd_i,
  output dmgt_status_t           status_o,
  input  logic [1:0]             opcode_i,
  input  logic [ElapsedBits-1:0] elapsed_i,
  input  logic [AddrBits-1:0]    address_i,
  input  logic [ByteBits-1:0]    write_data_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [ByteBits-1:0]    read_data_o,
  output logic                   timer_irq_o
);

  localparam int unsigned ClkBits = ElapsedBits + 2;
  // accumulator holds a remainder below 1024 plus one item's clocks
  localparam int unsigned AccBits = ((ClkBits > PeriodBits) ? ClkBits : PeriodBits) + 1;

  logic [DivBits-1:0]  div_q, div_d;
  logic [AccBits-1:0]  acc_q, acc_d;
  logic [ByteBits-1:0] tima_q, tima_d;
  logic [ByteBits-1:0] tma_q, tma_d;
  logic [CtrlBits-1:0] tac_q, tac_d;
  logic                irq_q, irq_d;

  logic [1:0]          op_q;
  logic [AddrBits-1:0] addr_q;
  logic [ByteBits-1:0] wdata_q;

  logic                out_valid_q;
  logic [ByteBits-1:0] rdata_q;
  logic                out_irq_q;

  logic [ClkBits-1:0]    clocks;
  logic [AccBits-1:0]    period;
  logic                  enabled;
  logic [ByteBits-1:0]   rdata;

  assign clocks  = {elapsed_i, 2'b00};
  assign enabled = tac_q[TacEnableBit];
  assign period  = AccBits'(step_period(tac_q[1:0]));

  assign status_o.step_due = enabled && (acc_q >= period);
  assign status_o.out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    rdata = 8'h00;
    if (op_q == OpRead) begin
      unique case (addr_q)
        AddrDiv:  rdata = div_q[DivBits-1 -: ByteBits];
        AddrTima: rdata = tima_q;
        AddrTma:  rdata = tma_q;
        AddrTac:  rdata = {5'b0, tac_q} | TacReadOnes;
        default:  rdata = OpenBus;
      endcase
    end
  end

  always_comb begin
    div_d  = div_q;
    acc_d  = acc_q;
    tima_d = tima_q;
    tma_d  = tma_q;
    tac_d  = tac_q;
    irq_d  = irq_q;
    if (cmd_i.load) begin
      div_d = div_q + DivBits'(clocks);
      irq_d = 1'b0;
      if (enabled) begin
        acc_d = acc_q + AccBits'(clocks);
      end
    end
    if (cmd_i.step) begin
      acc_d = acc_q - period;
      if (tima_q == CounterMax) begin
        tima_d = tma_q;
        irq_d  = 1'b1;
      end else begin
        tima_d = tima_q + 8'd1;
      end
    end
    if (cmd_i.finish && (op_q == OpWrite)) begin
      unique case (addr_q)
        AddrDiv:  div_d  = '0;
        AddrTima: tima_d = wdata_q;
        AddrTma:  tma_d  = wdata_q;
        AddrTac:  tac_d  = wdata_q[CtrlBits-1:0];
        default:  ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_q       <= '0;
      acc_q       <= '0;
      tima_q      <= '0;
      tma_q       <= '0;
      tac_q       <= '0;
      irq_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      div_q  <= div_d;
      acc_q  <= acc_d;
      tima_q <= tima_d;
      tma_q  <= tma_d;
      tac_q  <= tac_d;
      irq_q  <= irq_d;
      if (cmd_i.finish) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // transaction and result payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q    <= opcode_i;
      addr_q  <= address_i;
      wdata_q <= write_data_i;
    end
    if (cmd_i.finish) begin
      rdata_q   <= rdata;
      out_irq_q <= irq_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign read_data_o = rdata_q;
  assign timer_irq_o = out_irq_q;

`ifndef NO_ASSERTIONS
  a_step_only_enabled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.step |-> enabled)
    else $error("prescale step while timer disabled");

  a_acc_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.finish |=> (acc_q < AccBits'(1024)))
    else $error("accumulator not drained below largest period");

  a_irq_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load |=> !irq_q)
    else $error("overflow flag not cleared for new transaction");

  a_result_from_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(cmd_i.finish))
    else $error("result raised without finished transaction");
`endif

endmodule

@@ rtl/divider_and_reloading_timer.sv @@
// ----------------------------------------------------------------------------
// divider_and_reloading_timer
// An accepted transaction is loaded, then takes n prescale steps, where n is
//   (remainder + 4 * elapsed) / period when enabled, one step per cycle; the
//   result is registered when the output is free. No new transaction is taken
//   until the last one has finished.
// Reset clears the control and timer registers at once; no clearing pass.
// ----------------------------------------------------------------------------
module divider_and_reloading_timer import dmgt_pkg::*; #(
  parameter int unsigned ElapsedBits = ElapsedBitsDefault
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [1:0]             opcode_i,
  input  logic [ElapsedBits-1:0] elapsed_i,
  input  logic [AddrBits-1:0]    address_i,
  input  logic [ByteBits-1:0]    write_data_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [ByteBits-1:0]    read_data_o,
  output logic                   timer_irq_o
);

  dmgt_cmd_t    cmd;
  dmgt_status_t status;

  dmgt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  dmgt_datapath #(
    .ElapsedBits (ElapsedBits)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .opcode_i     (opcode_i),
    .elapsed_i    (elapsed_i),
    .address_i    (address_i),
    .write_data_i (write_data_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .read_data_o  (read_data_o),
    .timer_irq_o  (timer_irq_o)
  );

endmodule
